[rtl/btpc_pkg.sv]
// Shared types, constants and fixed-point helpers for the barometer compensation block.
package btpc_pkg;

    // Calibration words as unpacked from the configuration registers.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // Data that rides alongside the pressure through the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic        pvalid;
    } t_side;

    // One finished result.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        pvalid;
    } t_res;

    localparam int unsigned QuoBits = 64;

    localparam logic [1:0] RegTcal  = 2'd0;
    localparam logic [1:0] RegPlo   = 2'd1;
    localparam logic [1:0] RegPhi   = 2'd2;
    localparam logic [1:0] RegPlast = 2'd3;

    localparam logic signed [33:0] FineOffset = 34'sd128000;
    localparam logic signed [63:0] PresBias   = 64'sh0000_8000_0000_0000;
    localparam logic [20:0]        RawFull    = 21'd1048576;
    localparam logic signed [16:0] PresScale  = 17'sd3125;

    function automatic logic signed [16:0] sx17(input logic [15:0] v);
        return $signed({v[15], v});
    endfunction

    function automatic logic signed [63:0] sx64(input logic [15:0] v);
        return $signed({{48{v[15]}}, v});
    endfunction

    // Low 64 bits of a 64 by 17 bit signed product.
    function automatic logic signed [63:0] mul64x17(input logic signed [63:0] a,
                                                    input logic signed [16:0] b);
        logic signed [80:0] p;
        p = a * b;
        return $signed(p[63:0]);
    endfunction

    // Signed division by 2^k that truncates toward zero.
    function automatic logic signed [31:0] sdiv32(input logic signed [31:0] x,
                                                  input int unsigned k);
        logic [31:0] bias;
        logic [31:0] s;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        s    = x + bias;
        return $signed(s) >>> k;
    endfunction

    function automatic logic signed [63:0] sdiv64(input logic signed [63:0] x,
                                                  input int unsigned k);
        logic [63:0] bias;
        logic [63:0] s;
        bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
        s    = x + bias;
        return $signed(s) >>> k;
    endfunction

endpackage

[rtl/baro_temp_pressure_compensation.sv]
// Top level of the barometer temperature and pressure compensation pipeline.
//
// Each request carries one raw 20-bit temperature and one raw 20-bit pressure
// reading on i_raw_temperature and i_raw_pressure. A request is taken at a
// rising edge with i_in_valid high and o_in_stall low. Every request yields
// exactly one result on the output channel: the temperature in hundredths of a
// degree, the pressure in Q24.8 pascal and a flag that is low when the pressure
// divisor came out zero (the pressure then reads 0). A result is taken at an
// edge with o_out_valid high and i_out_stall low.
// Throughput is one request per cycle while o_in_stall is low. From acceptance
// to o_out_valid a request passes 8 front stages, a 66-stage divider (one
// restoring quotient bit per stage, plus operand and sign stages), 5 back
// stages and the output register. When the receiver stalls, the output
// register holds its result and one more result drops into a skid entry; after
// that the whole pipeline freezes and o_in_stall rises, so nothing is lost or
// repeated. Reset (synchronous, active low) empties the pipeline and clears all
// calibration registers to zero. Calibration is written over the APB port while
// the block is idle; the user must ensure this, as the block does not enforce
// it. Register i sits at byte address 8*i.
module baro_temp_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_temperature_centidegrees,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_pressure_valid,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import btpc_pkg::*;

    // Calibration registers.
    logic [47:0] r_tcal;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [15:0] r_plast;
    logic [1:0]  reg_idx;
    logic        wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal  <= '0;
            r_plo   <= '0;
            r_phi   <= '0;
            r_plast <= '0;
        end else if (wr) begin
            case (reg_idx)
                RegTcal:  r_tcal  <= pwdata[47:0];
                RegPlo:   r_plo   <= pwdata;
                RegPhi:   r_phi   <= pwdata;
                RegPlast: r_plast <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegTcal:  prdata = {16'd0, r_tcal};
            RegPlo:   prdata = r_plo;
            RegPhi:   prdata = r_phi;
            RegPlast: prdata = {48'd0, r_plast};
            default:  prdata = '0;
        endcase
    end

    // Unpack the calibration words for the datapath.
    t_cal cal;
    assign cal.t1 = r_tcal[15:0];
    assign cal.t2 = r_tcal[31:16];
    assign cal.t3 = r_tcal[47:32];
    assign cal.p1 = r_plo[15:0];
    assign cal.p2 = r_plo[31:16];
    assign cal.p3 = r_plo[47:32];
    assign cal.p4 = r_plo[63:48];
    assign cal.p5 = r_phi[15:0];
    assign cal.p6 = r_phi[31:16];
    assign cal.p7 = r_phi[47:32];
    assign cal.p8 = r_phi[63:48];
    assign cal.p9 = r_plast;

    // All pipeline stages advance together; only a full skid entry holds them.
    logic en;
    assign o_in_stall = !en;

    logic               f_valid;
    logic signed [63:0] f_num, f_den;
    t_side              f_side;

    btpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_raw_t (i_raw_temperature),
        .i_raw_p (i_raw_pressure),
        .i_cal   (cal),
        .o_valid (f_valid),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    logic               d_valid;
    logic signed [63:0] d_quo;
    t_side              d_side;

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    logic b_valid;
    t_res b_res;

    btpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_quo   (d_quo),
        .i_side  (d_side),
        .i_cal   (cal),
        .o_valid (b_valid),
        .o_res   (b_res)
    );

    t_res o_res;

    btpc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .i_res   (b_res),
        .o_en    (en),
        .o_valid (o_out_valid),
        .o_res   (o_res),
        .i_stall (i_out_stall)
    );

    assign o_temperature_centidegrees = o_res.temp;
    assign o_pressure_q24_8           = o_res.pres;
    assign o_pressure_valid           = o_res.pvalid;
endmodule

[rtl/btpc_front.sv]
// Front pipeline: fine temperature, temperature output, pressure dividend and divisor.
module btpc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [19:0]           i_raw_t,
    input  logic [19:0]           i_raw_p,
    input  btpc_pkg::t_cal        i_cal,
    output logic                  o_valid,
    output logic signed [63:0]    o_num,
    output logic signed [63:0]    o_den,
    output btpc_pkg::t_side       o_side
);
    import btpc_pkg::*;

    logic [8:1] r_v;

    // Stage 1
    logic signed [18:0] d1;
    logic signed [16:0] d2;
    logic signed [34:0] m1w;
    logic signed [33:0] m2w;
    logic signed [31:0] r_m1, r_m2;
    logic [19:0]        r_up1;

    assign d1  = $signed({2'b00, i_raw_t[19:3]}) - $signed({2'b00, i_cal.t1, 1'b0});
    assign d2  = $signed({1'b0, i_raw_t[19:4]}) - $signed({1'b0, i_cal.t1});
    assign m1w = d1 * $signed(i_cal.t2);
    assign m2w = d2 * d2;

    // Stage 2
    logic signed [31:0] q2;
    logic signed [47:0] m3w;
    logic signed [31:0] r_v1, r_m3;
    logic [19:0]        r_up2;

    assign q2  = sdiv32(r_m2, 12);
    assign m3w = q2 * $signed(i_cal.t3);

    // Stage 3
    logic signed [31:0] r_fine;
    logic [19:0]        r_up3;

    // Stage 4
    logic [31:0]        f5;
    logic signed [33:0] a34;
    logic signed [67:0] aaw;
    logic signed [50:0] ap5w, ap2w;
    logic signed [63:0] r_aa, r_ap5, r_ap2;
    logic [31:0]        r_temp4;
    logic [19:0]        r_up4;

    assign f5   = {r_fine[29:0], 2'b00} + r_fine + 32'd128;
    assign a34  = $signed({{2{r_fine[31]}}, r_fine}) - FineOffset;
    assign aaw  = a34 * a34;
    assign ap5w = a34 * $signed(i_cal.p5);
    assign ap2w = a34 * $signed(i_cal.p2);

    // Stage 5
    logic signed [63:0] r_b1, r_a1, r_ap5_5, r_ap2_5;
    logic [31:0]        r_temp5;
    logic [19:0]        r_up5;

    // Stage 6
    logic signed [63:0] r_b, r_s;
    logic [31:0]        r_temp6;
    logic [19:0]        r_up6;

    // Stage 7
    logic [20:0]        pd;
    logic signed [63:0] r_a0, r_n0;
    logic [31:0]        r_temp7;

    assign pd = RawFull - {1'b0, r_up6};

    // Stage 8
    logic signed [63:0] den;
    logic signed [63:0] r_num, r_den;
    t_side              r_side;

    assign den = sdiv64(r_a0, 33);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1  <= m1w[31:0];
            r_m2  <= m2w[31:0];
            r_up1 <= i_raw_p;

            r_v1  <= sdiv32(r_m1, 11);
            r_m3  <= m3w[31:0];
            r_up2 <= r_up1;

            r_fine <= r_v1 + sdiv32(r_m3, 14);
            r_up3  <= r_up2;

            r_temp4 <= sdiv32(f5, 8);
            r_aa    <= aaw[63:0];
            r_ap5   <= {{13{ap5w[50]}}, ap5w};
            r_ap2   <= {{13{ap2w[50]}}, ap2w};
            r_up4   <= r_up3;

            r_b1    <= mul64x17(r_aa, sx17(i_cal.p6));
            r_a1    <= mul64x17(r_aa, sx17(i_cal.p3));
            r_ap5_5 <= r_ap5;
            r_ap2_5 <= r_ap2;
            r_temp5 <= r_temp4;
            r_up5   <= r_up4;

            r_b     <= r_b1 + (r_ap5_5 << 17) + (sx64(i_cal.p4) << 35);
            r_s     <= sdiv64(r_a1, 8) + (r_ap2_5 << 12);
            r_temp6 <= r_temp5;
            r_up6   <= r_up5;

            r_a0    <= mul64x17(PresBias + r_s, $signed({1'b0, i_cal.p1}));
            r_n0    <= $signed({43'd0, pd} << 31) - r_b;
            r_temp7 <= r_temp6;

            r_den         <= den;
            r_num         <= mul64x17(r_n0, PresScale);
            r_side.temp   <= r_temp7;
            r_side.pvalid <= (den != 64'sd0);
        end
    end

    assign o_valid = r_v[8];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;
endmodule

[rtl/btpc_div.sv]
// Signed 64-bit divider pipeline, one restoring quotient bit per stage.
module btpc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [63:0]    i_num,
    input  logic signed [63:0]    i_den,
    input  btpc_pkg::t_side       i_side,
    output logic                  o_valid,
    output logic signed [63:0]    o_quo,
    output btpc_pkg::t_side       o_side
);
    import btpc_pkg::*;

    logic        r_v   [0:QuoBits];
    logic [63:0] r_rem [0:QuoBits];
    logic [63:0] r_quo [0:QuoBits];
    logic [63:0] r_dvs [0:QuoBits];
    logic        r_neg [0:QuoBits];
    t_side       r_sd  [0:QuoBits];

    logic              r_vo;
    logic signed [63:0] r_q;
    t_side             r_so;

    // Operand magnitudes and quotient sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_dvs[0] <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg[0] <= i_num[63] ^ i_den[63];
            r_sd[0]  <= i_side;
        end
    end

    for (genvar g = 0; g < QuoBits; g++) begin : g_bit
        logic [63:0] rem_sh;
        logic [64:0] diff;

        assign rem_sh = {r_rem[g][62:0], r_quo[g][63]};
        assign diff   = {1'b0, rem_sh} - {1'b0, r_dvs[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= diff[64] ? rem_sh : diff[63:0];
                r_quo[g+1] <= {r_quo[g][62:0], ~diff[64]};
                r_dvs[g+1] <= r_dvs[g];
                r_neg[g+1] <= r_neg[g];
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    // Sign restore; negating the magnitude wraps, as the division by minus one needs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[QuoBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q  <= r_neg[QuoBits] ? $signed(64'd0 - r_quo[QuoBits]) : $signed(r_quo[QuoBits]);
            r_so <= r_sd[QuoBits];
        end
    end

    assign o_valid = r_vo;
    assign o_quo   = r_q;
    assign o_side  = r_so;
endmodule

[rtl/btpc_back.sv]
// Back pipeline: second-order pressure correction and final Q24.8 scaling.
module btpc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [63:0]    i_quo,
    input  btpc_pkg::t_side       i_side,
    input  btpc_pkg::t_cal        i_cal,
    output logic                  o_valid,
    output btpc_pkg::t_res        o_res
);
    import btpc_pkg::*;

    logic [5:1] r_v;
    t_side      r_sd1, r_sd2, r_sd3, r_sd4;

    // Stage 1
    logic signed [63:0] qq;
    logic signed [63:0] r_p1, r_q, r_x, r_y;

    assign qq = sdiv64(i_quo, 13);

    // Stage 2: partial products for the low 64 bits of x times q.
    logic [63:0]        pp0w, pp1w, pp2w;
    logic [63:0]        r_pp0;
    logic [31:0]        r_pp1, r_pp2;
    logic signed [63:0] r_p2, r_b2;

    assign pp0w = {32'd0, r_x[31:0]} * {32'd0, r_q[31:0]};
    assign pp1w = {32'd0, r_x[63:32]} * {32'd0, r_q[31:0]};
    assign pp2w = {32'd0, r_x[31:0]} * {32'd0, r_q[63:32]};

    // Stage 3
    logic signed [63:0] r_a2, r_p3, r_b3;

    // Stage 4
    logic signed [63:0] r_sum;

    // Stage 5
    logic signed [63:0] res;
    t_res               r_res;

    assign res = sdiv64(r_sum, 8) + (sx64(i_cal.p7) << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= i_quo;
            r_q   <= qq;
            r_x   <= mul64x17(qq, sx17(i_cal.p9));
            r_y   <= mul64x17(i_quo, sx17(i_cal.p8));
            r_sd1 <= i_side;

            r_pp0 <= pp0w;
            r_pp1 <= pp1w[31:0];
            r_pp2 <= pp2w[31:0];
            r_b2  <= sdiv64(r_y, 19);
            r_p2  <= r_p1;
            r_sd2 <= r_sd1;

            r_a2  <= $signed(r_pp0 + {r_pp1 + r_pp2, 32'd0});
            r_b3  <= r_b2;
            r_p3  <= r_p2;
            r_sd3 <= r_sd2;

            r_sum <= r_p3 + sdiv64(r_a2, 25) + r_b3;
            r_sd4 <= r_sd3;

            r_res.temp   <= r_sd4.temp;
            r_res.pvalid <= r_sd4.pvalid;
            r_res.pres   <= r_sd4.pvalid ? res[31:0] : 32'd0;
        end
    end

    assign o_valid = r_v[5];
    assign o_res   = r_res;
endmodule

[rtl/btpc_outbuf.sv]
// Output register with one skid entry; it holds the pipeline when both are full.
module btpc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  btpc_pkg::t_res    i_res,
    output logic              o_en,
    output logic              o_valid,
    output btpc_pkg::t_res    o_res,
    input  logic              i_stall
);
    import btpc_pkg::*;

    logic r_o_v, r_s_v;
    t_res r_o, r_s;
    logic push;

    assign o_en = !r_s_v;
    assign push = i_valid && !r_s_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_o_v || !i_stall) begin
            if (r_s_v) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end else begin
                r_o_v <= push;
            end
        end else if (push) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || !i_stall) begin
            r_o <= r_s_v ? r_s : i_res;
        end else if (push) begin
            r_s <= i_res;
        end
    end

    assign o_valid = r_o_v;
    assign o_res   = r_o;
endmodule
